### src/s2cd_pkg.sv
// Shared types and constants for the serial-to-CAN command deframer.
// No dependencies; the top level refers to everything by scoped name.
package s2cd_pkg;

    localparam int FRAME_BUFFER_DEPTH = 16;
    localparam int COUNT_W            = 5;
    localparam int CHECK_AT           = 6;
    localparam int MAX_DATA_LEN       = 7;
    localparam int STD_OVERHEAD       = 6;
    localparam int EXT_OVERHEAD       = 8;
    localparam int MAX_FRAME_BYTES    = EXT_OVERHEAD + MAX_DATA_LEN;

    localparam logic [7:0] MODE_STANDARD = 8'd0;
    localparam logic [7:0] MODE_EXTENDED = 8'd1;

    typedef enum logic [1:0] {
        STATUS_TAKEN      = 2'd0,
        STATUS_COMPLETE   = 2'd1,
        STATUS_BAD_MODE   = 2'd2,
        STATUS_BAD_LENGTH = 2'd3
    } status_t;

endpackage

### src/serial_to_can_command_deframer.sv
// Serial-to-CAN command deframer: collects serial bytes into command frames and decodes them.
// Depends on s2cd_pkg for frame constants and status codes.
// Each input transfer's result is registered and appears on the m_ channel in the following cycle.
// Throughput: one byte per cycle; s_ready drops while a result is held and m_ready is low,
// and while reset is asserted.
// Reset (aresetn low, synchronous): byte count, send counter and output valid clear.
module serial_to_can_command_deframer #(
    parameter int FRAME_BUFFER_DEPTH = s2cd_pkg::FRAME_BUFFER_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic        m_extended_id,
    output logic [31:0] m_can_id,
    output logic [3:0]  m_can_length,
    output logic [63:0] m_can_payload,
    output logic [15:0] m_repeat_interval,
    output logic        m_repeat_enable
);

    localparam int IDX_W = $clog2(FRAME_BUFFER_DEPTH);
    localparam int CNT_W = s2cd_pkg::COUNT_W;

    // Frame store: written at the running byte index, read only at fixed places.
    logic [7:0]       frame_reg [FRAME_BUFFER_DEPTH];
    logic [7:0]       last_byte_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [7:0]       send_counter_reg, send_counter_next;

    // Result register
    logic                m_valid_reg;
    s2cd_pkg::status_t   status_reg, status_next;
    logic                ext_reg, ext_next;
    logic [31:0]         id_reg, id_next;
    logic [3:0]          len_reg, len_next;
    logic [63:0]         payload_reg, payload_next;
    logic [15:0]         interval_reg, interval_next;
    logic                rep_reg, rep_next;

    logic             s_fire;
    logic [CNT_W-1:0] count_eff;
    logic [CNT_W-1:0] count_inc;
    logic [IDX_W-1:0] wr_idx;
    logic [7:0]       mode_byte;
    logic [7:0]       len_byte;
    logic             is_ext;
    logic [2:0]       dlen;
    logic [CNT_W-1:0] total;
    logic [7:0]       pl_byte;

    // Accept while the result register is empty or being drained this cycle; hold off in reset.
    assign s_ready = aresetn && (!m_valid_reg || m_ready);
    assign s_fire  = s_valid && s_ready;

    // Restart the collector if it ever runs full (cannot happen with legal depth).
    assign count_eff = ({1'b0, count_reg} >= (CNT_W + 1)'(FRAME_BUFFER_DEPTH)) ?
                       '0 : count_reg;
    assign count_inc = count_eff + CNT_W'(1);
    assign wr_idx    = count_eff[IDX_W-1:0];

    // Mode is always stored by the time the check runs; the extended length byte
    // may be the one arriving right now, so bypass it from the input.
    assign mode_byte = frame_reg[0];
    assign is_ext    = (mode_byte == s2cd_pkg::MODE_EXTENDED);
    assign len_byte  = is_ext ? ((count_eff == CNT_W'(5)) ? s_rx_byte : frame_reg[5])
                              : frame_reg[3];
    assign dlen      = len_byte[2:0];
    assign total     = is_ext ? CNT_W'(s2cd_pkg::EXT_OVERHEAD) + CNT_W'(dlen)
                              : CNT_W'(s2cd_pkg::STD_OVERHEAD) + CNT_W'(dlen);

    always_comb begin
        count_next        = count_inc;
        send_counter_next = send_counter_reg;
        status_next       = s2cd_pkg::STATUS_TAKEN;
        ext_next          = 1'b0;
        id_next           = '0;
        len_next          = '0;
        payload_next      = '0;
        interval_next     = '0;
        rep_next          = 1'b0;
        pl_byte           = '0;

        if (count_inc >= CNT_W'(s2cd_pkg::CHECK_AT)) begin
            if (!(mode_byte inside {s2cd_pkg::MODE_STANDARD, s2cd_pkg::MODE_EXTENDED})) begin
                // Drop: unknown mode
                status_next = s2cd_pkg::STATUS_BAD_MODE;
                count_next  = '0;
            end else if (len_byte > 8'(s2cd_pkg::MAX_DATA_LEN)) begin
                // Drop: payload too long
                status_next = s2cd_pkg::STATUS_BAD_LENGTH;
                count_next  = '0;
            end else if (count_inc >= total) begin
                status_next = s2cd_pkg::STATUS_COMPLETE;
                count_next  = '0;
                ext_next    = is_ext;
                id_next     = is_ext ? {frame_reg[1], frame_reg[2], frame_reg[3], frame_reg[4]}
                                     : {16'd0, frame_reg[1], frame_reg[2]};
                // Payload bytes sit at fixed offsets after the identifier; the
                // rolling counter goes right after the last one.
                for (int i = 0; i < 8; i++) begin
                    pl_byte = '0;
                    if (i < 7 && 3'(i) < dlen) begin
                        pl_byte = is_ext ? frame_reg[6 + i] : frame_reg[4 + i];
                    end else if (i == 32'(dlen)) begin
                        pl_byte = send_counter_reg;
                    end
                    payload_next[8*i +: 8] = pl_byte;
                end
                // Interval is the previous byte and the one arriving now.
                interval_next     = {last_byte_reg, s_rx_byte};
                rep_next          = ({last_byte_reg, s_rx_byte} != 16'd0);
                len_next          = 4'(dlen) + 4'd1;
                send_counter_next = send_counter_reg + 8'd1;
            end
        end
    end

    // Frame store and last byte: payload only, no reset.
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            frame_reg[wr_idx] <= s_rx_byte;
            last_byte_reg     <= s_rx_byte;
        end
    end

    // Collector control state and result valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg        <= '0;
            send_counter_reg <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            if (s_fire) begin
                count_reg        <= count_next;
                send_counter_reg <= send_counter_next;
                m_valid_reg      <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            status_reg   <= status_next;
            ext_reg      <= ext_next;
            id_reg       <= id_next;
            len_reg      <= len_next;
            payload_reg  <= payload_next;
            interval_reg <= interval_next;
            rep_reg      <= rep_next;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_status          = status_reg;
    assign m_extended_id     = ext_reg;
    assign m_can_id          = id_reg;
    assign m_can_length      = len_reg;
    assign m_can_payload     = payload_reg;
    assign m_repeat_interval = interval_reg;
    assign m_repeat_enable   = rep_reg;

`ifndef SYNTHESIS
    // The collector never holds a whole frame's worth of bytes.
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg < CNT_W'(s2cd_pkg::MAX_FRAME_BYTES))
        else $error("byte count reached full frame size");

    // A completed frame carries one to eight payload bytes.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && status_reg == s2cd_pkg::STATUS_COMPLETE) |->
        (len_reg != 4'd0 && len_reg <= 4'd8))
        else $error("completed frame with bad length");

    // Anything but a completed frame reports all-zero decode fields.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && status_reg != s2cd_pkg::STATUS_COMPLETE) |->
        (!ext_reg && id_reg == '0 && len_reg == '0 && payload_reg == '0 &&
         interval_reg == '0 && !rep_reg))
        else $error("decode fields set on incomplete frame");

    // Each completed frame advances the send counter by one.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && status_next == s2cd_pkg::STATUS_COMPLETE) |=>
        (send_counter_reg == $past(send_counter_reg) + 8'd1))
        else $error("send counter did not advance");

    // Repeat flag follows the interval.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (rep_reg == (interval_reg != 16'd0)))
        else $error("repeat flag disagrees with interval");
`endif

endmodule
